// File: rtl/knn2c_pkg.sv
// knn2c_pkg: shared constants for the two-class nearest-neighbour classifier
// port field widths, default sizes, saturation limits, mode / label / verdict / status codes
// no dependencies
package knn2c_pkg;

    // default sizes for the top-level parameters
    localparam int NEIGHBOURS_DEF = 15;
    localparam int MAX_POINTS_DEF = 256;
    localparam int COORD_BITS_DEF = 10;

    // fixed port field widths
    localparam int POS_W     = 10;
    localparam int VERDICT_W = 2;
    localparam int VOTES_W   = 4;
    localparam int STORED_W  = 9;

    // output saturation limits
    localparam int VOTES_SAT  = 15;
    localparam int STORED_SAT = 511;

    // item modes
    localparam logic MODE_LOAD     = 1'b0;
    localparam logic MODE_CLASSIFY = 1'b1;

    // point classes
    localparam logic LABEL_CIRCLE = 1'b0;
    localparam logic LABEL_RECT   = 1'b1;

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_CIRCLE = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_RECT   = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_TIE    = 2'd2;

    // status codes
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

// File: rtl/knn_two_class_classifier.sv
// knn_two_class_classifier: point store, distance pipeline, sorted nearest list
// and vote tally for a two-class k-nearest-neighbour classifier
// depends on knn2c_pkg
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | input     | in_valid / in_ready | mode, pos_x, pos_y, label
//  out     | output    | out_valid/out_ready | verdict, circle_votes, rectangle_votes,
//          |           |                     | status, stored_points
//
// a load goes from the input transaction straight to the commit step; a classify
// scans all N stored points: the single read port of the point store delivers
// one point per cycle to a 4-stage distance pipeline, then the nearest list is
// tallied one entry per cycle
// reset clears point count, list fill, state and outputs; the store needs no clearing
// a new input transaction is taken while a result waits; the commit step holds until
// the output register is free, so out_ready low stalls only at that point
module knn_two_class_classifier #(
    parameter int NEIGHBOURS = knn2c_pkg::NEIGHBOURS_DEF,
    parameter int MAX_POINTS = knn2c_pkg::MAX_POINTS_DEF,
    parameter int COORD_BITS = knn2c_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               mode,
    input  logic [knn2c_pkg::POS_W-1:0]        pos_x,
    input  logic [knn2c_pkg::POS_W-1:0]        pos_y,
    input  logic                               label,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [knn2c_pkg::VERDICT_W-1:0]    verdict,
    output logic [knn2c_pkg::VOTES_W-1:0]      circle_votes,
    output logic [knn2c_pkg::VOTES_W-1:0]      rectangle_votes,
    output logic                               status,
    output logic [knn2c_pkg::STORED_W-1:0]     stored_points
);

    localparam int ADDR_W  = $clog2(MAX_POINTS);
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int SQ_W    = 2 * COORD_BITS;
    localparam int DIST_W  = 2 * COORD_BITS + 1;
    localparam int ENTRY_W = 2 * COORD_BITS + 1;
    localparam int VOTE_W  = $clog2(NEIGHBOURS + 1);
    localparam int KIDX_W  = (NEIGHBOURS > 1) ? $clog2(NEIGHBOURS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_TALLY,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // captured item
    logic                  mode_reg;
    logic                  label_reg;
    logic [COORD_BITS-1:0] qx_reg;
    logic [COORD_BITS-1:0] qy_reg;

    logic [CNT_W-1:0]  point_count_reg;
    logic [CNT_W-1:0]  scan_idx_reg;
    logic [VOTE_W-1:0] tally_idx_reg;
    logic [VOTE_W-1:0] circle_cnt_reg;
    logic [VOTE_W-1:0] rect_cnt_reg;

    // point store
    logic [ENTRY_W-1:0] store_mem [MAX_POINTS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [ENTRY_W-1:0] wr_data;
    logic               issue;

    // distance pipeline
    logic                  rv1_reg;
    logic                  v2_reg;
    logic                  v3_reg;
    logic                  v4_reg;
    logic [COORD_BITS-1:0] dx_reg;
    logic [COORD_BITS-1:0] dy_reg;
    logic                  cls2_reg;
    logic [SQ_W-1:0]       sqx_reg;
    logic [SQ_W-1:0]       sqy_reg;
    logic                  cls3_reg;
    logic [DIST_W-1:0]     dist_reg;
    logic                  cls4_reg;
    logic [COORD_BITS-1:0] ex;
    logic [COORD_BITS-1:0] ey;
    logic                  pipe_empty;

    // sorted nearest list, nearest first
    logic [DIST_W-1:0]     near_dist_reg  [NEIGHBOURS];
    logic                  near_cls_reg   [NEIGHBOURS];
    logic [NEIGHBOURS-1:0] near_valid_reg;
    logic [DIST_W-1:0]     near_dist_next [NEIGHBOURS];
    logic                  near_cls_next  [NEIGHBOURS];
    logic [NEIGHBOURS-1:0] near_valid_next;
    logic [NEIGHBOURS-1:0] farther;

    // commit decision
    logic                              slot_free;
    logic                              append_req;
    logic                              append_ok;
    logic                              app_label;
    logic [knn2c_pkg::VERDICT_W-1:0]   verdict_next;
    logic [CNT_W-1:0]                  count_after;
    logic                              tally_done;

    logic                              out_valid_reg;
    logic [knn2c_pkg::VERDICT_W-1:0]   verdict_reg;
    logic [knn2c_pkg::VOTES_W-1:0]     circle_votes_reg;
    logic [knn2c_pkg::VOTES_W-1:0]     rect_votes_reg;
    logic                              status_reg;
    logic [knn2c_pkg::STORED_W-1:0]    stored_reg;

    assign in_ready        = (state_reg == ST_IDLE);
    assign out_valid       = out_valid_reg;
    assign verdict         = verdict_reg;
    assign circle_votes    = circle_votes_reg;
    assign rectangle_votes = rect_votes_reg;
    assign status          = status_reg;
    assign stored_points   = stored_reg;

    assign issue      = (state_reg == ST_SCAN) && (scan_idx_reg != point_count_reg);
    assign pipe_empty = !rv1_reg && !v2_reg && !v3_reg && !v4_reg;
    assign tally_done = (tally_idx_reg == VOTE_W'(NEIGHBOURS));
    assign slot_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        append_req   = 1'b1;
        app_label    = label_reg;
        verdict_next = label_reg ? knn2c_pkg::VERDICT_RECT : knn2c_pkg::VERDICT_CIRCLE;
        if (mode_reg == knn2c_pkg::MODE_CLASSIFY)
        begin
            if (circle_cnt_reg > rect_cnt_reg)
            begin
                app_label    = knn2c_pkg::LABEL_CIRCLE;
                verdict_next = knn2c_pkg::VERDICT_CIRCLE;
            end
            else if (rect_cnt_reg > circle_cnt_reg)
            begin
                app_label    = knn2c_pkg::LABEL_RECT;
                verdict_next = knn2c_pkg::VERDICT_RECT;
            end
            else
            begin
                append_req   = 1'b0;
                verdict_next = knn2c_pkg::VERDICT_TIE;
            end
        end
        append_ok   = append_req && (point_count_reg < CNT_W'(MAX_POINTS));
        count_after = point_count_reg + CNT_W'(append_ok);
    end

    assign mem_we  = (state_reg == ST_FINISH) && slot_free && append_ok;
    assign wr_data = {qx_reg, qy_reg, app_label};

    // point store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[point_count_reg[ADDR_W-1:0]] <= wr_data;
        end
        rd_data_reg <= store_mem[scan_idx_reg[ADDR_W-1:0]];
    end

    assign ex = rd_data_reg[ENTRY_W-1:COORD_BITS+1];
    assign ey = rd_data_reg[COORD_BITS:1];

    // distance pipeline payload: abs difference, squares, sum
    always_ff @(posedge clk)
    begin
        dx_reg   <= (ex > qx_reg) ? (ex - qx_reg) : (qx_reg - ex);
        dy_reg   <= (ey > qy_reg) ? (ey - qy_reg) : (qy_reg - ey);
        cls2_reg <= rd_data_reg[0];
        sqx_reg  <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sqy_reg  <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        cls3_reg <= cls2_reg;
        dist_reg <= DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
        cls4_reg <= cls3_reg;
    end

    // insertion into the sorted list; an entry past the fill counts as farthest,
    // so a point equal to a kept one goes behind it and a full list drops the last
    always_comb
    begin
        for (int j = 0; j < NEIGHBOURS; j++)
        begin
            farther[j] = !near_valid_reg[j] || (near_dist_reg[j] > dist_reg);
        end
        near_dist_next[0]  = farther[0] ? dist_reg : near_dist_reg[0];
        near_cls_next[0]   = farther[0] ? cls4_reg : near_cls_reg[0];
        near_valid_next[0] = 1'b1;
        for (int j = 1; j < NEIGHBOURS; j++)
        begin
            near_valid_next[j] = near_valid_reg[j] || near_valid_reg[j-1];
            if (!farther[j])
            begin
                near_dist_next[j] = near_dist_reg[j];
                near_cls_next[j]  = near_cls_reg[j];
            end
            else if (farther[j-1])
            begin
                near_dist_next[j] = near_dist_reg[j-1];
                near_cls_next[j]  = near_cls_reg[j-1];
            end
            else
            begin
                near_dist_next[j] = dist_reg;
                near_cls_next[j]  = cls4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v4_reg)
        begin
            for (int j = 0; j < NEIGHBOURS; j++)
            begin
                near_dist_reg[j] <= near_dist_next[j];
                near_cls_reg[j]  <= near_cls_next[j];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            point_count_reg  <= '0;
            scan_idx_reg     <= '0;
            tally_idx_reg    <= '0;
            circle_cnt_reg   <= '0;
            rect_cnt_reg     <= '0;
            near_valid_reg   <= '0;
            rv1_reg          <= 1'b0;
            v2_reg           <= 1'b0;
            v3_reg           <= 1'b0;
            v4_reg           <= 1'b0;
            mode_reg         <= knn2c_pkg::MODE_LOAD;
            label_reg        <= knn2c_pkg::LABEL_CIRCLE;
            qx_reg           <= '0;
            qy_reg           <= '0;
            out_valid_reg    <= 1'b0;
            verdict_reg      <= knn2c_pkg::VERDICT_CIRCLE;
            circle_votes_reg <= '0;
            rect_votes_reg   <= '0;
            status_reg       <= knn2c_pkg::STATUS_OK;
            stored_reg       <= '0;
        end
        else
        begin
            rv1_reg <= issue;
            v2_reg  <= rv1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            if (v4_reg)
            begin
                near_valid_reg <= near_valid_next;
            end
            // the commit step sets out_valid itself
            if (out_valid_reg && out_ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        mode_reg       <= mode;
                        label_reg      <= label;
                        qx_reg         <= COORD_BITS'(pos_x);
                        qy_reg         <= COORD_BITS'(pos_y);
                        scan_idx_reg   <= '0;
                        tally_idx_reg  <= '0;
                        circle_cnt_reg <= '0;
                        rect_cnt_reg   <= '0;
                        near_valid_reg <= '0;
                        if (mode == knn2c_pkg::MODE_CLASSIFY)
                        begin
                            state_reg <= (point_count_reg == '0) ? ST_TALLY : ST_SCAN;
                        end
                        else
                        begin
                            state_reg <= ST_FINISH;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (issue)
                    begin
                        scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                    end
                    else if (pipe_empty)
                    begin
                        state_reg <= ST_TALLY;
                    end
                end
                ST_TALLY:
                begin
                    if (tally_done)
                    begin
                        state_reg <= ST_FINISH;
                    end
                    else
                    begin
                        tally_idx_reg <= tally_idx_reg + VOTE_W'(1);
                        if (near_valid_reg[tally_idx_reg[KIDX_W-1:0]])
                        begin
                            if (near_cls_reg[tally_idx_reg[KIDX_W-1:0]])
                            begin
                                rect_cnt_reg <= rect_cnt_reg + VOTE_W'(1);
                            end
                            else
                            begin
                                circle_cnt_reg <= circle_cnt_reg + VOTE_W'(1);
                            end
                        end
                    end
                end
                ST_FINISH:
                begin
                    if (slot_free)
                    begin
                        point_count_reg <= count_after;
                        out_valid_reg   <= 1'b1;
                        verdict_reg     <= verdict_next;
                        status_reg      <= (append_req && !append_ok) ?
                                           knn2c_pkg::STATUS_FULL : knn2c_pkg::STATUS_OK;
                        circle_votes_reg <= (32'(circle_cnt_reg) > 32'(knn2c_pkg::VOTES_SAT)) ?
                                            knn2c_pkg::VOTES_W'(knn2c_pkg::VOTES_SAT) :
                                            knn2c_pkg::VOTES_W'(circle_cnt_reg);
                        rect_votes_reg   <= (32'(rect_cnt_reg) > 32'(knn2c_pkg::VOTES_SAT)) ?
                                            knn2c_pkg::VOTES_W'(knn2c_pkg::VOTES_SAT) :
                                            knn2c_pkg::VOTES_W'(rect_cnt_reg);
                        stored_reg       <= (32'(count_after) > 32'(knn2c_pkg::STORED_SAT)) ?
                                            knn2c_pkg::STORED_W'(knn2c_pkg::STORED_SAT) :
                                            knn2c_pkg::STORED_W'(count_after);
                        state_reg        <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // the kept entries always form an unbroken run from the nearest slot
    a_near_prefix: assert property (@(posedge clk) disable iff (!rst_n)
        ((near_valid_reg + NEIGHBOURS'(1)) & near_valid_reg) == '0)
        else $error("nearest list has a hole");

    // the store grows by at most one point per cycle and never past its depth
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((point_count_reg == $past(point_count_reg)) ||
                  (point_count_reg == $past(point_count_reg) + CNT_W'(1))) &&
                 (point_count_reg <= CNT_W'(MAX_POINTS)))
        else $error("point count stepped wrongly");

    // every kept neighbour is counted exactly once by the tally
    a_tally_total: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TALLY && tally_done) |->
            (32'(circle_cnt_reg) + 32'(rect_cnt_reg) == $countones(near_valid_reg)))
        else $error("vote total differs from nearest fill");

    // no store write while the scan may still be reading
    a_write_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (pipe_empty && state_reg == ST_FINISH))
        else $error("store written during a scan");

endmodule

// File: verif/knn_two_class_classifier_test.sv
// knn_two_class_classifier_test: self-checking testbench for the two-class knn classifier
// directed table of loads and queries, then random traffic checked against a local predictor
// depends on knn2c_pkg and the knn_two_class_classifier rtl
`timescale 1ns / 100ps

module knn_two_class_classifier_test;

    localparam int NBR          = knn2c_pkg::NEIGHBOURS_DEF;
    localparam int STORE_DEPTH  = knn2c_pkg::MAX_POINTS_DEF;
    localparam int RAND_ITEMS   = 400;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = knn2c_pkg::MAX_POINTS_DEF + knn2c_pkg::NEIGHBOURS_DEF + 40;
    localparam int REPORT_MAX   = 10;

    localparam int POS_W     = knn2c_pkg::POS_W;
    localparam int VERDICT_W = knn2c_pkg::VERDICT_W;
    localparam int VOTES_W   = knn2c_pkg::VOTES_W;
    localparam int STORED_W  = knn2c_pkg::STORED_W;

    typedef struct packed {
        logic [VERDICT_W-1:0] verdict;
        logic [VOTES_W-1:0]   circle_votes;
        logic [VOTES_W-1:0]   rectangle_votes;
        logic                 status;
        logic [STORED_W-1:0]  stored_points;
    } knn_result_t;

    typedef struct packed {
        logic             mode;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             lab;
        logic             typed;
        knn_result_t      exp;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic                 mode;
    logic [POS_W-1:0]     pos_x;
    logic [POS_W-1:0]     pos_y;
    logic                 label;
    logic                 out_valid;
    logic                 out_ready;
    logic [VERDICT_W-1:0] verdict;
    logic [VOTES_W-1:0]   circle_votes;
    logic [VOTES_W-1:0]   rectangle_votes;
    logic                 status;
    logic [STORED_W-1:0]  stored_points;

    // travels with the payload so the monitor knows which rows carry a typed answer
    logic                 row_typed;
    knn_result_t          row_exp;

    // predictor copy of the point store
    logic [POS_W-1:0]     pt_x [STORE_DEPTH];
    logic [POS_W-1:0]     pt_y [STORE_DEPTH];
    logic                 pt_cls [STORE_DEPTH];
    int unsigned          pt_count = 0;

    knn_result_t          expected_q[$];
    stim_row_t            plan_q[$];
    int unsigned          fail_cnt = 0;
    int unsigned          cycle_cnt = 0;
    bit                   quiet_phase;
    int unsigned          n_loads = 0;
    int unsigned          n_queries = 0;
    int unsigned          n_circle = 0;
    int unsigned          n_rect = 0;
    int unsigned          n_tie = 0;
    int unsigned          n_full = 0;
    int unsigned          peak_store = 0;

    knn_two_class_classifier #(
        .NEIGHBOURS (knn2c_pkg::NEIGHBOURS_DEF),
        .MAX_POINTS (knn2c_pkg::MAX_POINTS_DEF),
        .COORD_BITS (knn2c_pkg::COORD_BITS_DEF)
    ) DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .label           (label),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .verdict         (verdict),
        .circle_votes    (circle_votes),
        .rectangle_votes (rectangle_votes),
        .status          (status),
        .stored_points   (stored_points)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic knn_result_t mk_result(input logic [VERDICT_W-1:0] v,
                                              input int unsigned c, input int unsigned r,
                                              input logic s, input int unsigned n);
        knn_result_t res;
        res.verdict         = v;
        res.circle_votes    = c[VOTES_W-1:0];
        res.rectangle_votes = r[VOTES_W-1:0];
        res.status          = s;
        res.stored_points   = n[STORED_W-1:0];
        return res;
    endfunction

    function automatic logic append_point(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                          input logic cls);
        if (pt_count >= STORE_DEPTH)
            return knn2c_pkg::STATUS_FULL;
        pt_x[pt_count]   = x;
        pt_y[pt_count]   = y;
        pt_cls[pt_count] = cls;
        pt_count++;
        return knn2c_pkg::STATUS_OK;
    endfunction

    // one item in, one result out; updates the predictor store
    function automatic knn_result_t predict_item(input logic m, input logic [POS_W-1:0] qx,
                                                 input logic [POS_W-1:0] qy, input logic lab);
        knn_result_t res;
        int unsigned near_dist [NBR];
        logic        near_cls [NBR];
        int unsigned kept, slot, sqd, dx, dy, circ, rect, i;
        logic [POS_W-1:0] cmask;
        cmask = POS_W'((1 << knn2c_pkg::COORD_BITS_DEF) - 1);
        qx = qx & cmask;
        qy = qy & cmask;
        res  = '0;
        circ = 0;
        rect = 0;
        kept = 0;
        if (m == knn2c_pkg::MODE_LOAD)
        begin
            res.verdict = lab ? knn2c_pkg::VERDICT_RECT : knn2c_pkg::VERDICT_CIRCLE;
            res.status  = append_point(qx, qy, lab);
        end
        else
        begin
            for (i = 0; i < pt_count; i++)
            begin
                dx  = (qx > pt_x[i]) ? qx - pt_x[i] : pt_x[i] - qx;
                dy  = (qy > pt_y[i]) ? qy - pt_y[i] : pt_y[i] - qy;
                sqd = dx * dx + dy * dy;
                // a tie with the worst kept entry does not displace it
                if (kept < NBR || sqd < near_dist[NBR-1])
                begin
                    if (kept < NBR)
                    begin
                        slot = kept;
                        kept++;
                    end
                    else
                        slot = NBR - 1;
                    while (slot > 0 && near_dist[slot-1] > sqd)
                    begin
                        near_dist[slot] = near_dist[slot-1];
                        near_cls[slot]  = near_cls[slot-1];
                        slot--;
                    end
                    near_dist[slot] = sqd;
                    near_cls[slot]  = pt_cls[i];
                end
            end
            for (i = 0; i < kept; i++)
            begin
                if (near_cls[i] == knn2c_pkg::LABEL_RECT)
                    rect++;
                else
                    circ++;
            end
            if (circ > rect)
            begin
                res.verdict = knn2c_pkg::VERDICT_CIRCLE;
                res.status  = append_point(qx, qy, knn2c_pkg::LABEL_CIRCLE);
            end
            else if (rect > circ)
            begin
                res.verdict = knn2c_pkg::VERDICT_RECT;
                res.status  = append_point(qx, qy, knn2c_pkg::LABEL_RECT);
            end
            else
                res.verdict = knn2c_pkg::VERDICT_TIE;
        end
        res.circle_votes    = VOTES_W'((circ > knn2c_pkg::VOTES_SAT) ?
                                       knn2c_pkg::VOTES_SAT : circ);
        res.rectangle_votes = VOTES_W'((rect > knn2c_pkg::VOTES_SAT) ?
                                       knn2c_pkg::VOTES_SAT : rect);
        res.stored_points   = STORED_W'((pt_count > knn2c_pkg::STORED_SAT) ?
                                        knn2c_pkg::STORED_SAT : pt_count);
        return res;
    endfunction

    function automatic void add_row(input logic m, input int unsigned x, input int unsigned y,
                                    input logic lab, input logic typed, input knn_result_t exp);
        stim_row_t row;
        row.mode  = m;
        row.x     = x[POS_W-1:0];
        row.y     = y[POS_W-1:0];
        row.lab   = lab;
        row.typed = typed;
        row.exp   = exp;
        plan_q    = {plan_q, row};
    endfunction

    // mostly short gaps, a few long ones, none at all in quiet phases
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(4, 60);
    endfunction

    function automatic logic [POS_W-1:0] pick_coord();
        logic [POS_W-1:0] c;
        c = POS_W'($urandom);
        case ($urandom_range(0, 9))
            0:       c = {POS_W{c[0]}};
            // coarse grid gives duplicates and many equal distances
            1, 2, 3: c = {c[2:0], 7'd0};
            default: ;
        endcase
        return c;
    endfunction

    // stimulus
    initial
    begin
        stim_row_t   row;
        int unsigned gap, k, idx;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        mode      = knn2c_pkg::MODE_LOAD;
        pos_x     = '0;
        pos_y     = '0;
        label     = knn2c_pkg::LABEL_CIRCLE;
        row_typed = 1'b0;
        row_exp   = '0;
        quiet_phase = 1'b0;

        // empty store, corners, fewer stored points than neighbours
        add_row(knn2c_pkg::MODE_CLASSIFY, 1023, 1023, knn2c_pkg::LABEL_RECT, 1'b1,
                mk_result(knn2c_pkg::VERDICT_TIE, 0, 0, knn2c_pkg::STATUS_OK, 0));
        add_row(knn2c_pkg::MODE_LOAD, 0, 0, knn2c_pkg::LABEL_CIRCLE, 1'b1,
                mk_result(knn2c_pkg::VERDICT_CIRCLE, 0, 0, knn2c_pkg::STATUS_OK, 1));
        add_row(knn2c_pkg::MODE_LOAD, 1023, 1023, knn2c_pkg::LABEL_RECT, 1'b1,
                mk_result(knn2c_pkg::VERDICT_RECT, 0, 0, knn2c_pkg::STATUS_OK, 2));
        add_row(knn2c_pkg::MODE_CLASSIFY, 512, 512, knn2c_pkg::LABEL_CIRCLE, 1'b1,
                mk_result(knn2c_pkg::VERDICT_TIE, 1, 1, knn2c_pkg::STATUS_OK, 2));
        add_row(knn2c_pkg::MODE_LOAD, 1023, 0, knn2c_pkg::LABEL_RECT, 1'b1,
                mk_result(knn2c_pkg::VERDICT_RECT, 0, 0, knn2c_pkg::STATUS_OK, 3));
        add_row(knn2c_pkg::MODE_CLASSIFY, 1000, 10, knn2c_pkg::LABEL_CIRCLE, 1'b1,
                mk_result(knn2c_pkg::VERDICT_RECT, 1, 2, knn2c_pkg::STATUS_OK, 4));
        add_row(knn2c_pkg::MODE_LOAD, 0, 1023, knn2c_pkg::LABEL_CIRCLE, 1'b1,
                mk_result(knn2c_pkg::VERDICT_CIRCLE, 0, 0, knn2c_pkg::STATUS_OK, 5));
        // sixteen points at one spot: only the first fifteen may vote
        for (k = 0; k < 16; k++)
            add_row(knn2c_pkg::MODE_LOAD, 200, 200,
                    (k >= 7 && k < 15) ? knn2c_pkg::LABEL_RECT : knn2c_pkg::LABEL_CIRCLE,
                    1'b0, '0);
        add_row(knn2c_pkg::MODE_CLASSIFY, 200, 200, knn2c_pkg::LABEL_CIRCLE, 1'b0, '0);

        // random part; about half loads so the store fills midway and stays full
        for (k = 0; k < RAND_ITEMS; k++)
            add_row($urandom_range(0, 1) ? knn2c_pkg::MODE_CLASSIFY : knn2c_pkg::MODE_LOAD,
                    pick_coord(), pick_coord(), 1'($urandom_range(0, 1)), 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (idx = 0; idx < plan_q.size(); idx++)
        begin
            row = plan_q[idx];
            if (idx % 50 == 0)
                quiet_phase = ($urandom_range(0, 3) == 0);
            gap = pick_gap();
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid  <= 1'b1;
            mode      <= row.mode;
            pos_x     <= row.x;
            pos_y     <= row.y;
            label     <= row.lab;
            row_typed <= row.typed;
            row_exp   <= row.exp;
            do
                @(posedge clk);
            while (!in_ready);
        end
        in_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d loads and %0d queries: %0d circle, %0d rectangle, %0d tie",
                 n_loads, n_queries, n_circle, n_rect, n_tie);
        $display("store peaked at %0d points, %0d results flagged full, %0d failures",
                 peak_store, n_full, fail_cnt);
        if (fail_cnt == 0)
            $display("knn_two_class_classifier_test OK");
        else
            $display("knn_two_class_classifier_test NOT OK");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        int unsigned gap;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            gap = pick_gap();
            if (gap != 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // prediction on input transactions, checking on output transactions
    always @(posedge clk)
    begin
        knn_result_t want, got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                want = predict_item(mode, pos_x, pos_y, label);
                if (row_typed)
                    want = row_exp;
                expected_q = {expected_q, want};
                if (mode == knn2c_pkg::MODE_LOAD)
                    n_loads++;
                else
                    n_queries++;
            end
            if (out_valid && out_ready)
            begin
                got = mk_result(verdict, circle_votes, rectangle_votes, status, stored_points);
                if (expected_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                        $display("%0t: result with nothing expected: verdict=%0d stored=%0d",
                                 $realtime, verdict, stored_points);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX)
                            $display({"%0t: mismatch verdict/circle/rect/status/stored ",
                                      "expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d"},
                                     $realtime, want.verdict, want.circle_votes,
                                     want.rectangle_votes, want.status, want.stored_points,
                                     got.verdict, got.circle_votes, got.rectangle_votes,
                                     got.status, got.stored_points);
                    end
                end
                case (verdict)
                    knn2c_pkg::VERDICT_CIRCLE: n_circle++;
                    knn2c_pkg::VERDICT_RECT:   n_rect++;
                    default:                   n_tie++;
                endcase
                if (status == knn2c_pkg::STATUS_FULL)
                    n_full++;
                if (stored_points > peak_store)
                    peak_store = stored_points;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_cnt, expected_q.size());
            $display("knn_two_class_classifier_test NOT OK");
            $finish;
        end
    end

endmodule
